// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the block averager.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define MCBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mcba assertion failed");

// Clocked check that also holds during reset.
`define MCBA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mcba assertion failed");

`endif

// ----- hw/rtl/mcba_pkg.sv -----
// Types and constants of the multichannel block averager.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package mcba_pkg;

	localparam int unsigned MASK_W    = 8;
	localparam int unsigned MAX_CH    = 8;
	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned SUM_W     = 21;
	localparam int unsigned CNT_W     = 9;
	localparam int unsigned CHAN_W    = 3;
	localparam int unsigned AVG_W     = 12;
	localparam int unsigned EFF_W     = 13;
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned STEP_W    = 5;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
	localparam logic [CNT_W-1:0] AVG_CNT_RESET = CNT_W'(1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [CNT_W-1:0]    cnt_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mcba_if.sv -----
// Valid/ready channels of the block averager: sample events in, averages out.
// Depends on mcba_pkg.
`default_nettype none

interface mcba_in_if;
	logic                          valid;
	logic                          ready;
	logic [mcba_pkg::MASK_W-1:0]   active_mask;
	mcba_pkg::sample_t             sample_ch0;
	mcba_pkg::sample_t             sample_ch1;
	mcba_pkg::sample_t             sample_ch2;
	mcba_pkg::sample_t             sample_ch3;
	mcba_pkg::sample_t             sample_ch4;
	mcba_pkg::sample_t             sample_ch5;
	mcba_pkg::sample_t             sample_ch6;
	mcba_pkg::sample_t             sample_ch7;

	modport source (
		output valid, active_mask, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		       sample_ch4, sample_ch5, sample_ch6, sample_ch7,
		input  ready
	);
	modport sink (
		input  valid, active_mask, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		       sample_ch4, sample_ch5, sample_ch6, sample_ch7,
		output ready
	);
endinterface

interface mcba_out_if;
	logic                          valid;
	logic                          ready;
	logic [mcba_pkg::CHAN_W-1:0]   channel;
	logic [mcba_pkg::AVG_W-1:0]    average;
	logic                          last;

	modport source (output valid, channel, average, last, input ready);
	modport sink (input valid, channel, average, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/multichannel_block_averager.sv -----
// Block averager: per-channel sums in a RAM, one serial divider, sequencer.
// Depends on mcba_pkg, mcba_if (mcba_in_if, mcba_out_if), mcba_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one conversion event per word and walks the channels in order: each channel
// passes a sum RAM read state and an add state that writes the sum back; a channel
// that emits an average skips that write and runs a 21-step restoring divider, then
// the output register, which waits while the output side stalls and clears the sum.
// samples.ready is high only between events, so the block takes no new event
// before it is through with the last one. The sum RAM comes out of reset cleared
// through per-entry valid bits, so no clearing pass is needed. average_count must be
// written only while the block is idle; the block itself does not enforce it.
module multichannel_block_averager #(
	parameter int unsigned CHANNELS    = 8,
	parameter int unsigned MAX_AVERAGE = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [mcba_pkg::CNT_W-1:0]  cfg_wdata,
	mcba_in_if.sink                          samples,
	mcba_out_if.source                       averages
);

	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_ADD,
		S_DIV,
		S_OUT
	} state_t;

	state_t                          state_q;
	logic [CH_W-1:0]                 ch_q;
	logic [CHANNELS-1:0]             used_q;
	logic [CHANNELS-1:0]             vld_q;
	mcba_pkg::sample_t               sample_q [CHANNELS];
	mcba_pkg::cnt_t                  cnt_q;
	mcba_pkg::cnt_t                  div_q;
	mcba_pkg::cnt_t                  avg_cnt_q;
	logic                            emit_q;
	mcba_pkg::sum_t                  quo_q;
	logic [mcba_pkg::CNT_W-1:0]      rem_q;
	logic [mcba_pkg::STEP_W-1:0]     step_q;
	logic                            out_valid_q;
	logic [mcba_pkg::CHAN_W-1:0]     out_chan_q;
	logic [mcba_pkg::AVG_W-1:0]      out_avg_q;
	logic                            out_last_q;

	mcba_pkg::sample_t               smp_w [mcba_pkg::MAX_CH];
	logic [CHANNELS-1:0]             used_w;
	mcba_pkg::cnt_t                  cnt_next;
	logic [mcba_pkg::EFF_W-1:0]      eff_w;
	logic                            emit_w;
	logic                            accept;
	mcba_pkg::sum_t                  rdata;
	mcba_pkg::sum_t                  rd_sum;
	logic [mcba_pkg::SUM_W:0]        add_w;
	mcba_pkg::sum_t                  sum_sat;
	logic                            ch_active;
	logic [mcba_pkg::CNT_W:0]        rem_sh;
	logic                            q_bit;
	logic [mcba_pkg::AVG_W-1:0]      avg_sat;
	logic                            last_w;
	logic                            out_free;
	logic                            ch_end;
	logic                            ram_we;
	mcba_pkg::sum_t                  ram_wdata;

	assign smp_w[0] = samples.sample_ch0;
	assign smp_w[1] = samples.sample_ch1;
	assign smp_w[2] = samples.sample_ch2;
	assign smp_w[3] = samples.sample_ch3;
	assign smp_w[4] = samples.sample_ch4;
	assign smp_w[5] = samples.sample_ch5;
	assign smp_w[6] = samples.sample_ch6;
	assign smp_w[7] = samples.sample_ch7;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign used_w        = samples.active_mask[CHANNELS-1:0];

	always_comb begin
		cnt_next = cnt_q;
		if ((|used_w) && (cnt_q != mcba_pkg::CNT_MAX)) begin
			cnt_next = cnt_q + mcba_pkg::CNT_W'(1);
		end
		eff_w = mcba_pkg::EFF_W'(avg_cnt_q);
		if (avg_cnt_q == '0) begin
			eff_w = mcba_pkg::EFF_W'(1);
		end else if (eff_w > mcba_pkg::EFF_W'(MAX_AVERAGE)) begin
			eff_w = mcba_pkg::EFF_W'(MAX_AVERAGE);
		end
		emit_w = (mcba_pkg::EFF_W'(cnt_next) >= eff_w);
	end

	mcba_ram #(
		.WIDTH (mcba_pkg::SUM_W),
		.DEPTH (CHANNELS)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_q),
		.wdata (ram_wdata),
		.re    (state_q == S_RD),
		.raddr (ch_q),
		.rdata (rdata)
	);

	always_comb begin
		ch_active = used_q[ch_q];
		rd_sum    = vld_q[ch_q] ? rdata : '0;
		add_w     = {1'b0, rd_sum} + (mcba_pkg::SUM_W + 1)'(sample_q[ch_q]);
		sum_sat   = add_w[mcba_pkg::SUM_W] ? mcba_pkg::SUM_MAX : add_w[mcba_pkg::SUM_W-1:0];

		rem_sh = {rem_q, quo_q[mcba_pkg::SUM_W-1]};
		q_bit  = (rem_sh >= {1'b0, div_q});

		avg_sat = (|quo_q[mcba_pkg::SUM_W-1:mcba_pkg::AVG_W]) ? mcba_pkg::AVG_MAX
			: quo_q[mcba_pkg::AVG_W-1:0];

		last_w = 1'b1;
		for (int i = 0; i < CHANNELS; i++) begin
			if ((i > int'(ch_q)) && used_q[i]) begin
				last_w = 1'b0;
			end
		end

		out_free = !out_valid_q || averages.ready;
		ch_end   = (ch_q == CH_W'(CHANNELS - 1));

		ram_we    = 1'b0;
		ram_wdata = sum_sat;
		if ((state_q == S_ADD) && ch_active && !emit_q) begin
			ram_we = 1'b1;
		end else if ((state_q == S_OUT) && out_free) begin
			ram_we    = 1'b1;
			ram_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			used_q      <= '0;
			vld_q       <= '0;
			cnt_q       <= '0;
			div_q       <= '0;
			avg_cnt_q   <= mcba_pkg::AVG_CNT_RESET;
			emit_q      <= 1'b0;
			quo_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			out_chan_q  <= '0;
			out_avg_q   <= '0;
			out_last_q  <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sample_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				avg_cnt_q <= cfg_wdata;
			end
			if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[ch_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						used_q <= used_w;
						for (int i = 0; i < CHANNELS; i++) begin
							sample_q[i] <= smp_w[i];
						end
						div_q   <= cnt_next;
						emit_q  <= emit_w;
						cnt_q   <= emit_w ? '0 : cnt_next;
						ch_q    <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (ch_active && emit_q) begin
						quo_q   <= sum_sat;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end else if (ch_end) begin
						state_q <= S_IDLE;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_RD;
					end
				end
				S_DIV: begin
					rem_q  <= q_bit ? mcba_pkg::CNT_W'(rem_sh - {1'b0, div_q})
						: rem_sh[mcba_pkg::CNT_W-1:0];
					quo_q  <= {quo_q[mcba_pkg::SUM_W-2:0], q_bit};
					step_q <= step_q + mcba_pkg::STEP_W'(1);
					if (step_q == mcba_pkg::STEP_W'(mcba_pkg::DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_chan_q  <= mcba_pkg::CHAN_W'(ch_q);
						out_avg_q   <= avg_sat;
						out_last_q  <= last_w;
						if (ch_end) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign averages.valid   = out_valid_q;
	assign averages.channel = out_chan_q;
	assign averages.average = out_avg_q;
	assign averages.last    = out_last_q;

	// divider only runs for a channel of an emitting event
	`MCBA_ASSERT(a_div_needs_emit, clk, arst_n, (state_q == S_DIV) |-> (emit_q && used_q[ch_q]))
	// an emitting event restarts the event counter
	`MCBA_ASSERT(a_emit_clears_cnt, clk, arst_n, (accept && emit_w) |=> (cnt_q == '0))
	// a new average only comes from the output step
	`MCBA_ASSERT(a_out_from_seq, clk, arst_n, $rose(averages.valid) |-> $past(state_q == S_OUT))

endmodule

`default_nettype wire

// ----- hw/rtl/mcba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mcba_ram #(
	parameter int unsigned WIDTH = 21,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- dv/multichannel_block_averager_tb.sv -----
// Testbench of multichannel_block_averager: directed and random sample events,
// averages predicted per event and checked word by word against the output channel.
// Depends on mcba_pkg, mcba_if and the block's RTL.
`timescale 1ns / 1ps

module multichannel_block_averager_tb;
	import mcba_pkg::*;

	localparam int unsigned CHANNELS      = 8;
	localparam int unsigned MAX_AVERAGE   = 256;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned MAX_REPORTS   = 10;

	typedef struct packed {
		logic [MASK_W-1:0]              mask;
		logic [MAX_CH-1:0][SAMPLE_W-1:0] smp;
	} sample_event_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [AVG_W-1:0]  average;
		logic              last;
	} avg_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cnt_t cfg_wdata;

	mcba_in_if  samples_if ();
	mcba_out_if averages_if ();

	multichannel_block_averager #(
		.CHANNELS    (CHANNELS),
		.MAX_AVERAGE (MAX_AVERAGE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples_if),
		.averages  (averages_if)
	);

	always #10 clk = ~clk;

	sample_event_t pending_events[$];
	avg_word_t     avg_expect_q[$];

	// predictor state
	sum_t chan_sums [MAX_CH];
	cnt_t block_events;
	cnt_t avg_count_reg;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	avg_word_t got_word;
	avg_word_t want_word;

	task automatic predict_averages(input sample_event_t ev);
		logic [SUM_W:0] total;
		sum_t           quot;
		int unsigned    limit_n;
		int             last_ch;
		avg_word_t      w;
		last_ch = -1;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (ev.mask[ch]) begin
				total = {1'b0, chan_sums[ch]} + ev.smp[ch];
				chan_sums[ch] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
				last_ch = ch;
			end
		end
		if (last_ch >= 0 && block_events != CNT_MAX)
			block_events = block_events + 1'b1;
		limit_n = (avg_count_reg == 0) ? 1 : avg_count_reg;
		if (limit_n > MAX_AVERAGE)
			limit_n = MAX_AVERAGE;
		if (block_events >= limit_n) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (ev.mask[ch]) begin
					quot = chan_sums[ch] / block_events;
					w.channel = CHAN_W'(ch);
					w.average = (quot > AVG_MAX) ? AVG_MAX : quot[AVG_W-1:0];
					w.last = (ch == last_ch);
					avg_expect_q.push_back(w);
					chan_sums[ch] = '0;
				end
			end
			block_events = '0;
		end
	endtask

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// driver: holds valid until the word is taken
	always @(posedge clk) begin
		if (samples_if.valid && samples_if.ready) begin
			predict_averages(pending_events[0]);
			void'(pending_events.pop_front());
		end
		if (!(samples_if.valid && !samples_if.ready)) begin
			if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				samples_if.active_mask <= pending_events[0].mask;
				samples_if.sample_ch0  <= pending_events[0].smp[0];
				samples_if.sample_ch1  <= pending_events[0].smp[1];
				samples_if.sample_ch2  <= pending_events[0].smp[2];
				samples_if.sample_ch3  <= pending_events[0].smp[3];
				samples_if.sample_ch4  <= pending_events[0].smp[4];
				samples_if.sample_ch5  <= pending_events[0].smp[5];
				samples_if.sample_ch6  <= pending_events[0].smp[6];
				samples_if.sample_ch7  <= pending_events[0].smp[7];
				samples_if.valid       <= 1'b1;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (averages_if.valid && averages_if.ready) begin
			got_word.channel = averages_if.channel;
			got_word.average = averages_if.average;
			got_word.last    = averages_if.last;
			if (avg_expect_q.size() == 0) begin
				note_failure($sformatf("unexpected word ch=%0d avg=%0d last=%0b",
					got_word.channel, got_word.average, got_word.last));
			end else begin
				want_word = avg_expect_q.pop_front();
				if (got_word.channel !== want_word.channel ||
				    got_word.average !== want_word.average ||
				    got_word.last !== want_word.last)
					note_failure($sformatf("exp ch=%0d avg=%0d last=%0b, got ch=%0d avg=%0d last=%0b",
						want_word.channel, want_word.average, want_word.last,
						got_word.channel, got_word.average, got_word.last));
			end
		end
		averages_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (averages_if.valid && averages_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [MASK_W-1:0] rand_mask();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return MASK_W'(1) << $urandom_range(MAX_CH - 1);
			default: return MASK_W'($urandom);
		endcase
	endfunction

	function automatic sample_event_t event_rand(input logic [MASK_W-1:0] mask);
		sample_event_t ev;
		ev.mask = mask;
		for (int ch = 0; ch < MAX_CH; ch++) begin
			case ($urandom_range(7))
				0: ev.smp[ch] = '0;
				1: ev.smp[ch] = '1;
				default: ev.smp[ch] = sample_t'($urandom);
			endcase
		end
		return ev;
	endfunction

	function automatic sample_event_t event_all(input logic [MASK_W-1:0] mask,
	                                            input sample_t value);
		sample_event_t ev;
		ev.mask = mask;
		for (int ch = 0; ch < MAX_CH; ch++)
			ev.smp[ch] = value;
		return ev;
	endfunction

	task automatic write_avg_count(input cnt_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		avg_count_reg = value;
	endtask

	task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// block may still be busy on a word with no output, hence the settle time
	task automatic drain();
		while (pending_events.size() != 0 || samples_if.valid || avg_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		samples_if.valid       = 1'b0;
		samples_if.active_mask = '0;
		samples_if.sample_ch0  = '0;
		samples_if.sample_ch1  = '0;
		samples_if.sample_ch2  = '0;
		samples_if.sample_ch3  = '0;
		samples_if.sample_ch4  = '0;
		samples_if.sample_ch5  = '0;
		samples_if.sample_ch6  = '0;
		samples_if.sample_ch7  = '0;
		averages_if.ready      = 1'b0;
		mismatch_count         = 0;
		quiet_cycles           = 0;
		block_events           = '0;
		avg_count_reg          = AVG_CNT_RESET;
		for (int ch = 0; ch < MAX_CH; ch++)
			chan_sums[ch] = '0;
		set_idle(0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset count of one: field extremes, empty mask
		pending_events.push_back(event_all(8'hFF, 12'hFFF));
		pending_events.push_back(event_all(8'hFF, 12'h000));
		pending_events.push_back(event_all(8'h00, 12'hFFF));
		pending_events.push_back(event_all(8'h55, 12'hAAA));
		pending_events.push_back(event_all(8'hAA, 12'h555));
		pending_events.push_back(event_rand(8'h01));
		pending_events.push_back(event_rand(8'h80));
		drain();

		// zero count behaves as one
		write_avg_count(9'd0);
		pending_events.push_back(event_rand(8'hFF));
		pending_events.push_back(event_rand(8'h3C));
		drain();

		// ch0 carried over a block while inactive, average saturates
		write_avg_count(9'd2);
		pending_events.push_back(event_all(8'h03, 12'hFFF));
		pending_events.push_back(event_all(8'h02, 12'hFFF));
		pending_events.push_back(event_all(8'h01, 12'hFFF));
		pending_events.push_back(event_all(8'h01, 12'hFFF));
		drain();

		// count lowered under a running block, then an empty mask restarts its event count
		write_avg_count(9'd4);
		pending_events.push_back(event_rand(8'h0F));
		pending_events.push_back(event_rand(8'hF0));
		drain();
		write_avg_count(9'd2);
		pending_events.push_back(event_all(8'h00, 12'h000));
		pending_events.push_back(event_rand(8'h01));
		pending_events.push_back(event_rand(8'h01));
		drain();

		write_avg_count(9'd1);
		repeat (25) pending_events.push_back(event_rand(rand_mask()));
		drain();

		set_idle(79, 0);
		write_avg_count(cnt_t'($urandom_range(8, 2)));
		repeat (25) pending_events.push_back(event_rand(rand_mask()));
		drain();

		set_idle(0, 79);
		write_avg_count(cnt_t'($urandom_range(8, 0)));
		repeat (25) pending_events.push_back(event_rand(rand_mask()));
		drain();

		set_idle(38, 38);
		write_avg_count(cnt_t'($urandom_range(16, 1)));
		repeat (30) pending_events.push_back(event_rand(rand_mask()));
		drain();

		// count above the maximum: no average within a short run
		set_idle(0, 0);
		write_avg_count(9'd511);
		repeat (8) pending_events.push_back(event_rand(rand_mask()));
		drain();

		if (mismatch_count == 0 && avg_expect_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
